/* hdl/stq_pkg.sv */
package stq_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int TIME_BITS = 32;
    localparam int TAG_BITS  = 16;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);

    typedef enum logic [1:0] {
        ACT_ARM_ABS = 2'd0,
        ACT_ARM_REL = 2'd1,
        ACT_DISARM  = 2'd2,
        ACT_TICK    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        logic                 valid;
        logic [SLOT_BITS-1:0] slot;
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] expiry;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        logic     pop;
        entry_t   key;
    } cell_cmd_t;

endpackage

/* hdl/sorted_timer_queue.sv */
// Channel  Direction  tdata / tuser / tlast
// s_       in         tdata: slot, when, delta, now, tag; tuser: action
// m_       out        tdata: fired_slot, fired_tag, fired_expiry; tlast: last
//
// A disarm removes the slot's entry; an arm removes it, then inserts it in sorted order.
// A tick first loads the time, then fires each due slot in turn and returns
// to idle once no slot is due; each fired word leaves the head of
// the cell chain, so the output rate is one word per cycle while m_tready
// stays high.
// Reset clears every cell's valid bit, the current time and the output valid flag.
// A stalled output word holds the tick until it is taken.
module sorted_timer_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] slot, [35:4] when, [67:36] delta, [99:68] now, [115:100] tag
    input  logic [119:0] s_tdata,
    // [1:0] action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] fired_slot, [19:4] fired_tag, [51:20] fired_expiry
    output logic [55:0]  m_tdata,
    output logic         m_tlast
);
    import stq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_FIRE
    } state_t;

    state_t               state_reg;
    logic [TIME_BITS-1:0] now_reg;
    entry_t               key_reg;
    logic                 out_valid_reg;
    entry_t               out_entry_reg;
    logic                 out_last_reg;

    logic [SLOT_BITS-1:0] in_slot;
    logic [TIME_BITS-1:0] in_when;
    logic [TIME_BITS-1:0] in_delta;
    logic [TIME_BITS-1:0] in_now;
    logic [TAG_BITS-1:0]  in_tag;
    action_t              in_action;
    logic                 in_accept;

    cell_cmd_t cmd;
    entry_t    cell_entry [NUM_SLOTS];
    logic      cell_le    [NUM_SLOTS];
    logic      cell_match [NUM_SLOTS];
    logic      head_due;
    logic      second_due;
    logic      out_free;
    logic      pop;

    assign in_slot   = s_tdata[3:0];
    assign in_when   = s_tdata[35:4];
    assign in_delta  = s_tdata[67:36];
    assign in_now    = s_tdata[99:68];
    assign in_tag    = s_tdata[115:100];
    assign in_action = action_t'(s_tuser);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign head_due   = cell_entry[0].valid && (cell_entry[0].expiry <= now_reg);
    assign second_due = cell_entry[1].valid && (cell_entry[1].expiry <= now_reg);
    assign out_free   = !out_valid_reg || m_tready;
    assign pop        = (state_reg == ST_FIRE) && out_free && head_due;

    always_comb begin
        cmd           = '0;
        cmd.op        = OP_HOLD;
        cmd.key       = key_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && in_action != ACT_TICK) begin
                    cmd.op       = OP_SHIFT;
                    cmd.key.slot = in_slot;
                end
            end
            ST_INSERT: begin
                cmd.op = OP_INSERT;
            end
            ST_FIRE: begin
                if (pop) begin
                    cmd.op  = OP_SHIFT;
                    cmd.pop = 1'b1;
                end
            end
            default: begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_l;
        logic   match_i;
        if (i == 0) begin : g_first
            assign prev_e  = '0;
            assign prev_l  = 1'b1;
            assign match_i = cmd.pop;
        end else begin : g_rest
            assign prev_e  = cell_entry[i-1];
            assign prev_l  = cell_le[i-1];
            assign match_i = cell_match[i-1];
        end
        if (i == NUM_SLOTS - 1) begin : g_last
            assign next_e = '0;
        end else begin : g_more
            assign next_e = cell_entry[i+1];
        end
        stq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .prev_entry (prev_e),
            .prev_le    (prev_l),
            .next_entry (next_e),
            .match_in   (match_i),
            .entry      (cell_entry[i]),
            .le_out     (cell_le[i]),
            .match_out  (cell_match[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready && !pop) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        key_reg.valid <= 1'b1;
                        key_reg.slot  <= in_slot;
                        key_reg.tag   <= in_tag;
                        case (in_action)
                            ACT_ARM_ABS: begin
                                key_reg.expiry <= in_when;
                                state_reg      <= ST_INSERT;
                            end
                            ACT_ARM_REL: begin
                                key_reg.expiry <= now_reg + in_delta;
                                state_reg      <= ST_INSERT;
                            end
                            ACT_TICK: begin
                                now_reg   <= in_now;
                                state_reg <= ST_FIRE;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_INSERT: begin
                    state_reg <= ST_IDLE;
                end
                ST_FIRE: begin
                    if (out_free) begin
                        if (head_due) begin
                            out_valid_reg <= 1'b1;
                            out_entry_reg <= cell_entry[0];
                            out_last_reg  <= !second_due;
                            if (!second_due) begin
                                state_reg <= ST_IDLE;
                            end
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_entry_reg.expiry, out_entry_reg.tag, out_entry_reg.slot};
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/stq_cell.sv */
module stq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  stq_pkg::cell_cmd_t cmd,
    input  stq_pkg::entry_t    prev_entry,
    input  logic               prev_le,
    input  stq_pkg::entry_t    next_entry,
    input  logic               match_in,
    output stq_pkg::entry_t    entry,
    output logic               le_out,
    output logic               match_out
);
    import stq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   own_le;
    logic   own_match;

    always_comb begin
        own_le     = entry_reg.valid && (entry_reg.expiry <= cmd.key.expiry);
        own_match  = entry_reg.valid && (entry_reg.slot == cmd.key.slot);
        match_out  = match_in || own_match;
        entry_next = entry_reg;
        case (cmd.op)
            OP_SHIFT: begin
                if (match_out) begin
                    entry_next = next_entry;
                end
            end
            OP_INSERT: begin
                if (!own_le) begin
                    entry_next = prev_le ? cmd.key : prev_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry  = entry_reg;
    assign le_out = own_le;

endmodule
